[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define PAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising edge, off during reset
`define PAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pac_pkg.sv]
package pac_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int MAX_VERTICES_DEF = 256;
  localparam int AREA_W           = 40;
  localparam int DIFF_W           = COORD_WIDTH + 1;
  localparam int PROD_W           = 2 * DIFF_W;
  localparam int SHOE_W           = 2 * COORD_WIDTH;

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic                          last;
  } in_beat_t;

  typedef struct packed {
    logic [AREA_W-1:0] area_doubled;
    logic              convex;
    logic              too_many;
  } out_beat_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } vertex_t;

  typedef struct packed {
    sign_t ref_sign;
    logic  convex;
  } track_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] lhs;
    logic signed [PROD_W-1:0] rhs;
  } turn_prod_t;

  typedef struct packed {
    logic signed [SHOE_W-1:0] ab;
    logic signed [SHOE_W-1:0] ba;
  } shoe_prod_t;

  // closing snapshot handed from the accumulator to the closing stages
  typedef struct packed {
    vertex_t first;
    vertex_t second;
    vertex_t older;
    vertex_t prev;
    track_t  track;
    logic    few;
    logic    many;
  } snap_t;

  localparam track_t TRACK_INIT = '{ref_sign: SIGN_NONE, convex: 1'b1};

  // accumulator width: every shoelace term fits in 2*COORD_WIDTH bits plus sign
  function automatic int sum_width(int max_vertices);
    return 2 * COORD_WIDTH + 2 + $clog2(max_vertices + 1);
  endfunction

  // the two products of the turn a -> b -> c
  function automatic turn_prod_t turn_products(vertex_t a, vertex_t b, vertex_t c);
    logic signed [DIFF_W-1:0] dx_ab;
    logic signed [DIFF_W-1:0] dy_ab;
    logic signed [DIFF_W-1:0] dx_bc;
    logic signed [DIFF_W-1:0] dy_bc;
    turn_prod_t r;
    dx_ab = DIFF_W'(b.x) - DIFF_W'(a.x);
    dy_ab = DIFF_W'(b.y) - DIFF_W'(a.y);
    dx_bc = DIFF_W'(c.x) - DIFF_W'(b.x);
    dy_bc = DIFF_W'(c.y) - DIFF_W'(b.y);
    r.lhs = dx_ab * dy_bc;
    r.rhs = dy_ab * dx_bc;
    return r;
  endfunction

  function automatic shoe_prod_t shoe_products(vertex_t a, vertex_t b);
    shoe_prod_t r;
    r.ab = a.x * b.y;
    r.ba = b.x * a.y;
    return r;
  endfunction

  function automatic sign_t turn_sign(turn_prod_t p);
    sign_t s;
    if (p.lhs > p.rhs) begin
      s = SIGN_POS;
    end else if (p.lhs < p.rhs) begin
      s = SIGN_NEG;
    end else begin
      s = SIGN_NONE;
    end
    return s;
  endfunction

  // collinear turns leave the tracker alone
  function automatic track_t merge_turn(track_t t, sign_t s);
    track_t r;
    r = t;
    if (s != SIGN_NONE) begin
      if (t.ref_sign == SIGN_NONE) begin
        r.ref_sign = s;
      end else if (t.ref_sign != s) begin
        r.convex = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

[rtl/pac_accum.sv]
`include "assert_macros.svh"

module pac_accum #(
  parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    advance,
  input  logic                                    valid,
  input  pac_pkg::in_beat_t                       beat,
  output logic                                    snap_valid,
  output pac_pkg::snap_t                          snap,
  output logic signed [pac_pkg::sum_width(MAX_VERTICES)-1:0] snap_sum
);

  localparam int SUM_W = pac_pkg::sum_width(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_VERTICES + 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(3);

  pac_pkg::vertex_t    first_r, first_nxt;
  pac_pkg::vertex_t    second_r, second_nxt;
  pac_pkg::vertex_t    older_r, older_nxt;
  pac_pkg::vertex_t    prev_r, prev_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  pac_pkg::track_t     track_r, track_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  pac_pkg::snap_t      snap_r, snap_nxt;
  logic signed [SUM_W-1:0] snap_sum_r;
  logic                snap_valid_r;

  pac_pkg::vertex_t    cur;
  pac_pkg::turn_prod_t turn_p;
  pac_pkg::shoe_prod_t shoe_p;
  logic signed [SUM_W-1:0] term;

  assign cur.x = beat.vertex_x;
  assign cur.y = beat.vertex_y;

  always_comb begin
    turn_p = pac_pkg::turn_products(older_r, prev_r, cur);
    shoe_p = pac_pkg::shoe_products(prev_r, cur);
    term   = SUM_W'(shoe_p.ab) - SUM_W'(shoe_p.ba);

    first_nxt  = first_r;
    second_nxt = second_r;
    older_nxt  = older_r;
    prev_nxt   = prev_r;
    sum_nxt    = sum_r;
    track_nxt  = track_r;
    count_nxt  = count_r;

    if (count_r < CNT_MAX) begin
      if (count_r == '0) begin
        first_nxt = cur;
      end else begin
        if (count_r == CNT_ONE) begin
          second_nxt = cur;
        end else begin
          track_nxt = pac_pkg::merge_turn(track_r, pac_pkg::turn_sign(turn_p));
        end
        sum_nxt = sum_r + term;
      end
      older_nxt = prev_r;
      prev_nxt  = cur;
      count_nxt = count_r + 1'b1;
    end else begin
      // vertices past the limit are dropped
      count_nxt = CNT_SAT;
    end

    snap_nxt.first  = first_nxt;
    snap_nxt.second = second_nxt;
    snap_nxt.older  = older_nxt;
    snap_nxt.prev   = prev_nxt;
    snap_nxt.track  = track_nxt;
    snap_nxt.many   = (count_nxt == CNT_SAT);
    snap_nxt.few    = (count_nxt != CNT_SAT) && (count_nxt < CNT_MIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      track_r      <= pac_pkg::TRACK_INIT;
      count_r      <= '0;
      snap_valid_r <= 1'b0;
    end else if (advance) begin
      snap_valid_r <= valid && beat.last;
      if (valid) begin
        if (beat.last) begin
          sum_r   <= '0;
          track_r <= pac_pkg::TRACK_INIT;
          count_r <= '0;
        end else begin
          sum_r   <= sum_nxt;
          track_r <= track_nxt;
          count_r <= count_nxt;
        end
      end
    end
  end

  // vertex history only matters once the count says so
  always_ff @(posedge clk) begin
    if (advance && valid) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      older_r  <= older_nxt;
      prev_r   <= prev_nxt;
      if (beat.last) begin
        snap_r     <= snap_nxt;
        snap_sum_r <= sum_nxt;
      end
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;
  assign snap_sum   = snap_sum_r;

  `PAC_ASSERT_NEXT(a_clear_after_last, advance && valid && beat.last,
                   count_r == '0 && sum_r == '0 && track_r == pac_pkg::TRACK_INIT,
                   "accumulator not cleared after closing vertex")
  `PAC_ASSERT_NOW(a_nonconvex_has_sign, !track_r.convex,
                  track_r.ref_sign != pac_pkg::SIGN_NONE,
                  "convexity lost without a reference sign")
  `PAC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_SAT,
                  "vertex count beyond saturation")

endmodule

[rtl/pac_close.sv]
`include "assert_macros.svh"

module pac_close #(
  parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    advance,
  input  logic                                    snap_valid,
  input  pac_pkg::snap_t                          snap,
  input  logic signed [pac_pkg::sum_width(MAX_VERTICES)-1:0] snap_sum,
  output logic                                    out_valid,
  output pac_pkg::out_beat_t                      out_beat
);

  localparam int SUM_W  = pac_pkg::sum_width(MAX_VERTICES);
  localparam int AREA_W = pac_pkg::AREA_W;
  localparam int EXT_W  = ((SUM_W > AREA_W) ? SUM_W : AREA_W) + 1;

  // product stage
  logic                c1_valid_r;
  pac_pkg::turn_prod_t turn_a_r;
  pac_pkg::turn_prod_t turn_b_r;
  pac_pkg::shoe_prod_t shoe_r;
  pac_pkg::track_t     c1_track_r;
  logic                c1_few_r;
  logic                c1_many_r;
  logic signed [SUM_W-1:0] c1_sum_r;

  // result stage
  logic                out_valid_r;
  pac_pkg::out_beat_t  out_beat_r, out_beat_nxt;

  pac_pkg::track_t     track_a, track_b;
  logic signed [SUM_W-1:0] sum_fin;
  logic [SUM_W-1:0]    mag;
  logic [EXT_W-1:0]    mag_ext;

  always_comb begin
    track_a = pac_pkg::merge_turn(c1_track_r, pac_pkg::turn_sign(turn_a_r));
    track_b = pac_pkg::merge_turn(track_a, pac_pkg::turn_sign(turn_b_r));
    sum_fin = c1_sum_r + SUM_W'(shoe_r.ab) - SUM_W'(shoe_r.ba);
    mag     = sum_fin[SUM_W-1] ? -sum_fin : sum_fin;
    mag_ext = EXT_W'(mag);

    out_beat_nxt.too_many = c1_many_r;
    if (c1_few_r) begin
      out_beat_nxt.area_doubled = '0;
      out_beat_nxt.convex       = 1'b1;
    end else begin
      out_beat_nxt.area_doubled = (|mag_ext[EXT_W-1:AREA_W]) ? '1 : mag_ext[AREA_W-1:0];
      out_beat_nxt.convex       = track_b.convex;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      c1_valid_r  <= snap_valid;
      out_valid_r <= c1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // wrap-around turns and the closing shoelace term
      turn_a_r   <= pac_pkg::turn_products(snap.older, snap.prev, snap.first);
      turn_b_r   <= pac_pkg::turn_products(snap.prev, snap.first, snap.second);
      shoe_r     <= pac_pkg::shoe_products(snap.prev, snap.first);
      c1_track_r <= snap.track;
      c1_few_r   <= snap.few;
      c1_many_r  <= snap.many;
      c1_sum_r   <= snap_sum;
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  `PAC_ASSERT_NEXT(a_result_follows, advance && c1_valid_r, out_valid_r,
                   "closing result lost between stages")

endmodule

[rtl/polygon_area_convexity_top.sv]
// result path: the last-vertex beat passes the input register, accumulator snapshot, product stage and result stage
// throughput: one vertex beat per cycle while in_stall is low, back to back, across polygon boundaries
// the four multipliers of the accumulator set the cycle; closing work runs in two stages
// the whole pipe holds while a finished result is stalled at the output
// reset (rst_n low, synchronous) empties the pipe and clears the polygon state at once

module polygon_area_convexity_top #(
  parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pac_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output pac_pkg::out_beat_t  out_beat
);

  localparam int SUM_W = pac_pkg::sum_width(MAX_VERTICES);

  // input register
  logic              in_valid_r;
  pac_pkg::in_beat_t in_beat_r;

  // pipe moves whenever the output register is free or being drained
  logic advance;

  // accumulator to closing stages
  logic                    snap_valid;
  pac_pkg::snap_t          snap;
  logic signed [SUM_W-1:0] snap_sum;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (advance) begin
      in_valid_r <= in_valid;
    end
  end

  // payload capture only on an accepted beat
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      in_beat_r <= in_beat;
    end
  end

  // running shoelace sum, turn sign tracking and vertex history
  pac_accum #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .valid      (in_valid_r),
    .beat       (in_beat_r),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_sum   (snap_sum)
  );

  // wrap-around turns, closing term, absolute value and saturation
  pac_close #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_close (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_sum   (snap_sum),
    .out_valid  (out_valid),
    .out_beat   (out_beat)
  );

endmodule
